/* rtl/ook_pwm_frame_decoder_defines.svh */
// ----------------------------------------------------------------------------
// OOK PWM frame decoder assertion macros
// Shared property shorthands; each expands in a scope with clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef OOK_PWM_FRAME_DECODER_DEFINES_SVH
`define OOK_PWM_FRAME_DECODER_DEFINES_SVH

// same-cycle implication
`define OFD_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("ofd assertion failed");

// next-cycle implication
`define OFD_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("ofd assertion failed");

`endif

/* rtl/ofd_pkg.sv */
// ----------------------------------------------------------------------------
// OOK PWM frame decoder package
// Payload and config types, register indexes, reset values, length match.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ofd_pkg;

	localparam int CODE_BITS = 64;

	typedef struct packed {
		logic        level;
		logic [15:0] duration;
	} in_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] code;
		logic [6:0]           bit_count;
	} out_t;

	typedef struct packed {
		logic [11:0] short_unit;
		logic [11:0] long_unit;
		logic [9:0]  tolerance;
		logic [6:0]  min_frame_bits;
		logic [7:0]  min_preamble_pairs;
	} cfg_t;

	// classified pulse, as queued between front and back
	typedef struct packed {
		logic        level;
		logic [15:0] duration;
		logic        near_short;
		logic        near_start;
		logic        near_long;
		logic        at_gap;
	} cls_t;

	localparam logic [2:0] REG_SHORT_UNIT    = 3'd0;
	localparam logic [2:0] REG_LONG_UNIT     = 3'd1;
	localparam logic [2:0] REG_TOLERANCE     = 3'd2;
	localparam logic [2:0] REG_MIN_BITS      = 3'd3;
	localparam logic [2:0] REG_MIN_PREAMBLE  = 3'd4;

	localparam logic [11:0] RST_SHORT_UNIT   = 12'd200;
	localparam logic [11:0] RST_LONG_UNIT    = 12'd400;
	localparam logic [9:0]  RST_TOLERANCE    = 10'd80;
	localparam logic [6:0]  RST_MIN_BITS     = 7'd56;
	localparam logic [7:0]  RST_MIN_PREAMBLE = 8'd40;

	localparam logic [6:0] BITS_SAT  = 7'd127;
	localparam logic [7:0] PAIRS_SAT = 8'd255;

	// |d - n| < tol
	function automatic logic near_len(input logic [15:0] d, input logic [15:0] n,
			input logic [9:0] tol);
		logic [15:0] diff;
		diff = (d > n) ? (d - n) : (n - d);
		return diff < {6'd0, tol};
	endfunction

	function automatic logic [15:0] start_len(input logic [11:0] su);
		return {2'd0, su, 2'd0};
	endfunction

endpackage

/* rtl/ofd_front.sv */
// ----------------------------------------------------------------------------
// OOK PWM frame decoder front end
// Holds the config registers and classifies each pulse length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ofd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	input  logic [2:0]    cfg_index,
	input  logic [11:0]   cfg_data,
	input  ofd_pkg::in_t  item,
	output ofd_pkg::cls_t cls,
	output ofd_pkg::cfg_t cfg
);

	ofd_pkg::cfg_t cfg_q;
	logic [16:0]   gap_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_unit         <= ofd_pkg::RST_SHORT_UNIT;
			cfg_q.long_unit          <= ofd_pkg::RST_LONG_UNIT;
			cfg_q.tolerance          <= ofd_pkg::RST_TOLERANCE;
			cfg_q.min_frame_bits     <= ofd_pkg::RST_MIN_BITS;
			cfg_q.min_preamble_pairs <= ofd_pkg::RST_MIN_PREAMBLE;
		end else if (cfg_valid) begin
			case (cfg_index)
				ofd_pkg::REG_SHORT_UNIT:   cfg_q.short_unit <= cfg_data;
				ofd_pkg::REG_LONG_UNIT:    cfg_q.long_unit <= cfg_data;
				ofd_pkg::REG_TOLERANCE:    cfg_q.tolerance <= cfg_data[9:0];
				ofd_pkg::REG_MIN_BITS:     cfg_q.min_frame_bits <= cfg_data[6:0];
				ofd_pkg::REG_MIN_PREAMBLE: cfg_q.min_preamble_pairs <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// stop gap: 10 short units plus two tolerances (short*8 + short*2)
	assign gap_len = {2'd0, cfg_q.short_unit, 3'd0} + {4'd0, cfg_q.short_unit, 1'b0}
		+ {6'd0, cfg_q.tolerance, 1'b0};

	always_comb begin
		cls.level      = item.level;
		cls.duration   = item.duration;
		cls.near_short = ofd_pkg::near_len(item.duration, {4'd0, cfg_q.short_unit},
			cfg_q.tolerance);
		cls.near_start = ofd_pkg::near_len(item.duration,
			ofd_pkg::start_len(cfg_q.short_unit), cfg_q.tolerance);
		cls.near_long  = ofd_pkg::near_len(item.duration, {4'd0, cfg_q.long_unit},
			cfg_q.tolerance);
		cls.at_gap     = {1'b0, item.duration} >= gap_len;
	end

	assign cfg = cfg_q;

endmodule

/* rtl/ofd_queue.sv */
// ----------------------------------------------------------------------------
// OOK PWM frame decoder queue
// Two-entry FIFO of classified pulses between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ofd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ofd_pkg::cls_t wr_data,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output ofd_pkg::cls_t rd_data
);

	ofd_pkg::cls_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full    = count_q[1];
	assign empty   = (count_q == 2'd0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/ofd_back.sv */
// ----------------------------------------------------------------------------
// OOK PWM frame decoder back end
// Frame sequencer: preamble count, bit decode, stop detect, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ofd_back #(
	parameter int CODE_WIDTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ofd_pkg::cfg_t cfg,
	input  logic          empty,
	input  ofd_pkg::cls_t cls,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output ofd_pkg::out_t out_data
);

	localparam logic [1:0] PH_IDLE     = 2'd0;
	localparam logic [1:0] PH_PREAMBLE = 2'd1;
	localparam logic [1:0] PH_HIGH     = 2'd2;
	localparam logic [1:0] PH_LOW      = 2'd3;

	logic [1:0]            phase_q, phase_d;
	logic [15:0]           last_high_q, last_high_d;
	logic [7:0]            pairs_q, pairs_d;
	logic [CODE_WIDTH-1:0] shift_q, shift_d, shift_push;
	logic [6:0]            bits_q, bits_d, bits_push;
	logic                  out_valid_q;
	ofd_pkg::out_t         out_data_q;
	logic                  emit;
	logic                  push_bit, bit_val;
	logic                  last_short, last_start, last_long;

	assign pop = !empty && (!out_valid_q || out_ready);

	assign last_short = ofd_pkg::near_len(last_high_q, {4'd0, cfg.short_unit}, cfg.tolerance);
	assign last_start = ofd_pkg::near_len(last_high_q, ofd_pkg::start_len(cfg.short_unit),
		cfg.tolerance);
	assign last_long  = ofd_pkg::near_len(last_high_q, {4'd0, cfg.long_unit}, cfg.tolerance);

	assign shift_push = {shift_q[CODE_WIDTH-2:0], bit_val};
	assign bits_push  = (bits_q == ofd_pkg::BITS_SAT) ? bits_q : bits_q + 7'd1;

	always_comb begin
		phase_d     = phase_q;
		last_high_d = last_high_q;
		pairs_d     = pairs_q;
		shift_d     = shift_q;
		bits_d      = bits_q;
		emit        = 1'b0;
		push_bit    = 1'b0;
		bit_val     = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (cls.level && cls.near_short) begin
					phase_d     = PH_PREAMBLE;
					last_high_d = cls.duration;
					pairs_d     = 8'd0;
				end
			end
			PH_PREAMBLE: begin
				if (cls.level) begin
					if (cls.near_short || cls.near_start) begin
						last_high_d = cls.duration;
					end else begin
						phase_d = PH_IDLE;
					end
				end else if (cls.near_short && last_short) begin
					if (pairs_q != ofd_pkg::PAIRS_SAT) begin
						pairs_d = pairs_q + 8'd1;
					end
				end else if (cls.near_short && last_start
						&& (pairs_q > cfg.min_preamble_pairs)) begin
					phase_d = PH_HIGH;
					shift_d = '0;
					bits_d  = 7'd0;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_HIGH: begin
				if (cls.level) begin
					last_high_d = cls.duration;
					phase_d     = PH_LOW;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (cls.level) begin
					phase_d = PH_IDLE;
				end else if (cls.at_gap) begin
					// stop gap: last bit from the pending high, then judge the frame
					push_bit = last_short || last_long;
					bit_val  = !last_short;
					emit     = ((push_bit ? bits_push : bits_q) >= cfg.min_frame_bits);
					shift_d  = '0;
					bits_d   = 7'd0;
				end else if (last_short && cls.near_long) begin
					push_bit = 1'b1;
					shift_d  = shift_push;
					bits_d   = bits_push;
					phase_d  = PH_HIGH;
				end else if (last_long && cls.near_short) begin
					push_bit = 1'b1;
					bit_val  = 1'b1;
					shift_d  = shift_push;
					bits_d   = bits_push;
					phase_d  = PH_HIGH;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			last_high_q <= 16'd0;
			pairs_q     <= 8'd0;
			shift_q     <= '0;
			bits_q      <= 7'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				last_high_q <= last_high_d;
				pairs_q     <= pairs_d;
				shift_q     <= shift_d;
				bits_q      <= bits_d;
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_data_q.code      <= ofd_pkg::CODE_BITS'(push_bit ? shift_push : shift_q);
			out_data_q.bit_count <= push_bit ? bits_push : bits_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* rtl/ook_pwm_frame_decoder.sv */
// ----------------------------------------------------------------------------
// OOK PWM frame decoder
// Decodes pulse-width coded on-off-keyed remote frames from demodulated pulses.
// ----------------------------------------------------------------------------
// One pulse transaction (level, duration) is taken per clock while in_ready is
// high. The edge that accepts a pulse writes its classification into a
// two-entry queue; the back-end frame sequencer pops it when the result
// register is free or being taken and loads the result register, so out_valid
// rises once the pulse that ends a frame is popped, and the register holds the
// code until it is taken. Sustained rate is one pulse per cycle while the
// output is not stalled; a stalled output lets the queue fill before
// in_ready drops. Durations are matched as |d - n| < tolerance against the
// short, four-short (start) and long units; a low of 10 short units plus two
// tolerances ends a frame. The code holds the newest CODE_WIDTH bits, newest
// in bit 0, upper bits zero. Config writes are always accepted (cfg_ready is
// tied high) and must be issued only while no pulse is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ook_pwm_frame_decoder #(
	parameter int CODE_WIDTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	// pulse channel
	input  logic          in_valid,
	output logic          in_ready,
	input  ofd_pkg::in_t  in_data,
	// result channel
	output logic          out_valid,
	input  logic          out_ready,
	output ofd_pkg::out_t out_data,
	// config write channel
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [11:0]   cfg_data
);

	ofd_pkg::cls_t front_cls;
	ofd_pkg::cls_t head_cls;
	ofd_pkg::cfg_t cfg;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	logic          q_push;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign q_push    = in_valid && !q_full;

	// front: config registers and per-pulse length classification
	ofd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (in_data),
		.cls       (front_cls),
		.cfg       (cfg)
	);

	// decoupling queue
	ofd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (front_cls),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.rd_data (head_cls)
	);

	// back: frame sequencer and result register
	ofd_back #(
		.CODE_WIDTH (CODE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.empty     (q_empty),
		.cls       (head_cls),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* rtl/ofd_checker.sv */
// ----------------------------------------------------------------------------
// OOK PWM frame decoder checker
// Port-level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ook_pwm_frame_decoder_defines.svh"

module ofd_checker #(
	parameter int CODE_WIDTH = 64
) (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input ofd_pkg::out_t out_data,
	input logic          cfg_ready
);

	logic code_fits;

	assign code_fits = ((out_data.code >> CODE_WIDTH) == '0);

	// stalled result holds
	`OFD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	// code never carries bits above CODE_WIDTH
	`OFD_ASSERT_IMP(a_code_width, out_valid, code_fits)
	// input backpressure only follows an output stall
	`OFD_ASSERT_IMP(a_in_stall, !in_ready, $past(out_valid && !out_ready))
	// config port never stalls
	`OFD_ASSERT_IMP(a_cfg_ready, in_valid || !in_valid, cfg_ready)

endmodule

bind ook_pwm_frame_decoder ofd_checker #(.CODE_WIDTH(CODE_WIDTH)) u_ofd_checker (.*);
